/* sv/hps_pkg.sv */
package hps_pkg;

    // Widths fixed by the register map and the sample format.
    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 24;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int DERR_W     = ERR_W + 1;
    localparam int ACC_W      = 26;
    localparam int FRAC_SHIFT = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    // Register values after reset.
    localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RST     = 16'sd7680;
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST       = 16'd38400;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST      = 16'd1280;
    localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST      = 16'd12800;
    localparam logic [LIMIT_W-1:0]       INTEG_LIMIT_RST     = 24'd665600;
    localparam int                       MAX_DUTY_RST        = 6500;
    localparam logic signed [TEMP_W-1:0] OVER_TEMP_LIMIT_RST = 16'sd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_TEMP     = 3'd0,
        REG_PROP_GAIN       = 3'd1,
        REG_INTEG_GAIN      = 3'd2,
        REG_DERIV_GAIN      = 3'd3,
        REG_INTEG_LIMIT     = 3'd4,
        REG_MAX_DUTY        = 3'd5,
        REG_OVER_TEMP_LIMIT = 3'd6
    } reg_idx_t;

endpackage

/* sv/hps_if.sv */
interface hps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hps_pkg::TEMP_W-1:0]    measured_temp;

    modport source (output valid, output measured_temp, input ready);
    modport sink   (input valid, input measured_temp, output ready);
endinterface

interface hps_out_if #(
    parameter int DUTY_BITS = 13
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] heater_duty;
    logic                 over_temp;

    modport source (output valid, output heater_duty, output over_temp, input ready);
    modport sink   (input valid, input heater_duty, input over_temp, output ready);
endinterface

/* sv/heater_pid_step_top.sv */
// Heater PID controller step. Each transfer on sample_ch carries one temperature
// sample in signed Q8.8 degrees C and produces exactly one transfer on result_ch
// with a heater duty count and an over-temperature flag. A sample above the
// over-temperature limit forces the duty to zero, raises over_temp and clears the
// integral; otherwise the block runs one PID step with a fixed 0.5 s period, an
// integral clamped to plus or minus integ_limit, and a duty clamped to 0..max_duty.
// The datapath is a four-stage pipeline: sample register, error and integral update,
// the three gain multiplications, then the sum, clamp and output register. One sample
// can be taken in every cycle while the result side keeps accepting; the rate is set by
// the integral and error update in stage 2, which closes the only loop in the design.
// Each stage stalls only when it is full and the stage after it cannot move, so new
// samples keep being taken while a result waits, until every stage is full.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and must
// only be changed while no sample is in flight.
module heater_pid_step_top #(
    parameter int DUTY_BITS = 13
) (
    input  logic                             clk,
    input  logic                             rst_n,
    hps_in_if.sink                           sample_ch,
    hps_out_if.source                        result_ch,
    input  logic                             cfg_we,
    input  logic [hps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int TEMP_W  = hps_pkg::TEMP_W;
    localparam int GAIN_W  = hps_pkg::GAIN_W;
    localparam int LIMIT_W = hps_pkg::LIMIT_W;
    localparam int ERR_W   = hps_pkg::ERR_W;
    localparam int DERR_W  = hps_pkg::DERR_W;
    localparam int ACC_W   = hps_pkg::ACC_W;
    localparam int FRAC    = hps_pkg::FRAC_SHIFT;
    localparam int ISUM_W  = ACC_W + 1;
    localparam int PKP_W   = GAIN_W + 1 + ERR_W;
    localparam int PKI_W   = GAIN_W + 1 + ACC_W;
    localparam int PKD_W   = GAIN_W + 1 + DERR_W;
    localparam int SUM_W   = PKI_W + 2;

    // Configuration registers.
    logic signed [TEMP_W-1:0]  target_temp_reg;
    logic [GAIN_W-1:0]         prop_gain_reg;
    logic [GAIN_W-1:0]         integ_gain_reg;
    logic [GAIN_W-1:0]         deriv_gain_reg;
    logic [LIMIT_W-1:0]        integ_limit_reg;
    logic [DUTY_BITS-1:0]      max_duty_reg;
    logic signed [TEMP_W-1:0]  over_temp_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg     <= hps_pkg::TARGET_TEMP_RST;
            prop_gain_reg       <= hps_pkg::PROP_GAIN_RST;
            integ_gain_reg      <= hps_pkg::INTEG_GAIN_RST;
            deriv_gain_reg      <= hps_pkg::DERIV_GAIN_RST;
            integ_limit_reg     <= hps_pkg::INTEG_LIMIT_RST;
            max_duty_reg        <= DUTY_BITS'(hps_pkg::MAX_DUTY_RST);
            over_temp_limit_reg <= hps_pkg::OVER_TEMP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            // Bits above a register's width are dropped; unused indexes are ignored.
            case (hps_pkg::reg_idx_t'(cfg_index))
                hps_pkg::REG_TARGET_TEMP:     target_temp_reg     <= signed'(cfg_data[TEMP_W-1:0]);
                hps_pkg::REG_PROP_GAIN:       prop_gain_reg       <= cfg_data[GAIN_W-1:0];
                hps_pkg::REG_INTEG_GAIN:      integ_gain_reg      <= cfg_data[GAIN_W-1:0];
                hps_pkg::REG_DERIV_GAIN:      deriv_gain_reg      <= cfg_data[GAIN_W-1:0];
                hps_pkg::REG_INTEG_LIMIT:     integ_limit_reg     <= cfg_data[LIMIT_W-1:0];
                hps_pkg::REG_MAX_DUTY:        max_duty_reg        <= cfg_data[DUTY_BITS-1:0];
                hps_pkg::REG_OVER_TEMP_LIMIT: over_temp_limit_reg <= signed'(cfg_data[TEMP_W-1:0]);
                default:                      ;
            endcase
        end
    end

    // Pipeline flow control. A stage may load when it is empty or when its
    // contents move on in the same cycle.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s3_load;
    logic s2_load;
    logic s1_load;

    assign out_load        = !out_valid_reg || result_ch.ready;
    assign s3_load         = !s3_valid_reg  || out_load;
    assign s2_load         = !s2_valid_reg  || s3_load;
    assign s1_load         = !s1_valid_reg  || s2_load;
    assign sample_ch.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= sample_ch.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_load)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: sample register.
    logic signed [TEMP_W-1:0] s1_temp_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_temp_reg <= sample_ch.measured_temp;
        end
    end

    // Stage 2: error, clamped integral and error change. The controller state
    // is updated here, once per sample, as the sample moves into stage 2.
    logic signed [ACC_W-1:0]   integ_acc_reg;
    logic signed [ACC_W-1:0]   integ_acc_next;
    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [ERR_W-1:0]   prev_error_next;
    logic                      over_next;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ISUM_W-1:0]  ilim;
    logic signed [ACC_W-1:0]   integ_clamped;
    logic signed [DERR_W-1:0]  derr_next;

    always_comb
    begin
        over_next = s1_temp_reg > over_temp_limit_reg;
        err_next  = ERR_W'(target_temp_reg) - ERR_W'(s1_temp_reg);
        isum      = ISUM_W'(integ_acc_reg) + ISUM_W'(err_next);
        ilim      = signed'(ISUM_W'(integ_limit_reg));
        if (isum > ilim)
        begin
            integ_clamped = ACC_W'(ilim);
        end
        else if (isum < -ilim)
        begin
            integ_clamped = ACC_W'(-ilim);
        end
        else
        begin
            integ_clamped = ACC_W'(isum);
        end
        derr_next = DERR_W'(err_next) - DERR_W'(prev_error_reg);

        // The cut-off clears the integral and keeps the last error.
        if (over_next)
        begin
            integ_acc_next  = '0;
            prev_error_next = prev_error_reg;
        end
        else
        begin
            integ_acc_next  = integ_clamped;
            prev_error_next = err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_acc_reg  <= '0;
            prev_error_reg <= '0;
        end
        else if (s2_load && s1_valid_reg)
        begin
            integ_acc_reg  <= integ_acc_next;
            prev_error_reg <= prev_error_next;
        end
    end

    logic                     s2_over_reg;
    logic signed [ERR_W-1:0]  s2_err_reg;
    logic signed [ACC_W-1:0]  s2_integ_reg;
    logic signed [DERR_W-1:0] s2_derr_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_over_reg  <= over_next;
            s2_err_reg   <= err_next;
            s2_integ_reg <= integ_acc_next;
            s2_derr_reg  <= derr_next;
        end
    end

    // Stage 3: the three gain products, each 17 by at most 26 bits.
    logic signed [PKP_W-1:0] pkp_next;
    logic signed [PKI_W-1:0] pki_next;
    logic signed [PKD_W-1:0] pkd_next;

    always_comb
    begin
        pkp_next = PKP_W'(signed'({1'b0, prop_gain_reg}))  * PKP_W'(s2_err_reg);
        pki_next = PKI_W'(signed'({1'b0, integ_gain_reg})) * PKI_W'(s2_integ_reg);
        pkd_next = PKD_W'(signed'({1'b0, deriv_gain_reg})) * PKD_W'(s2_derr_reg);
    end

    logic                    s3_over_reg;
    logic signed [PKP_W-1:0] s3_pkp_reg;
    logic signed [PKI_W-1:0] s3_pki_reg;
    logic signed [PKD_W-1:0] s3_pkd_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_over_reg <= s2_over_reg;
            s3_pkp_reg  <= pkp_next;
            s3_pki_reg  <= pki_next;
            s3_pkd_reg  <= pkd_next;
        end
    end

    // Stage 4: exact sum in units of 2^-17 duty counts, clamp and truncate.
    // The proportional term carries the factor two of the 0.5 s period and the
    // derivative term the factor four of the period and the Q8.8 scaling.
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] duty_top;
    logic [DUTY_BITS-1:0]    duty_next;

    always_comb
    begin
        sum = (SUM_W'(s3_pkp_reg) <<< 1) + SUM_W'(s3_pki_reg) + (SUM_W'(s3_pkd_reg) <<< 2);
        duty_top = signed'(SUM_W'({max_duty_reg, {FRAC{1'b0}}}));
        if (s3_over_reg || sum < 0)
        begin
            duty_next = '0;
        end
        else if (sum > duty_top)
        begin
            duty_next = max_duty_reg;
        end
        else
        begin
            duty_next = sum[FRAC +: DUTY_BITS];
        end
    end

    logic [DUTY_BITS-1:0] out_duty_reg;
    logic                 out_over_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_duty_reg <= duty_next;
            out_over_reg <= s3_over_reg;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.heater_duty = out_duty_reg;
    assign result_ch.over_temp   = out_over_reg;

endmodule

/* sv/hps_checker.sv */
module hps_checker #(
    parameter int DUTY_BITS = 13
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [DUTY_BITS-1:0] heater_duty,
    input logic                 over_temp
);

    // Samples taken but whose results have not yet been transferred.
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heater_duty) && $stable(over_temp))
        else $error("result changed while stalled");

    a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && over_temp |-> heater_duty == '0)
        else $error("over-temperature result with non-zero duty");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("sample refused while the output is empty");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result without a pending sample");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more samples in flight than pipeline stages");

endmodule

bind heater_pid_step_top hps_checker #(
    .DUTY_BITS (DUTY_BITS)
) u_hps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .heater_duty (result_ch.heater_duty),
    .over_temp   (result_ch.over_temp)
);

/* tb/hps_duty_checker.sv */
`timescale 1ns / 100ps

module hps_duty_checker #(
    parameter int DUTY_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hps_in_if                               sample_ch,
    hps_out_if                              result_ch,
    input  logic                            cfg_we,
    input  logic [hps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              checked,
    output int                              cutoffs
);
    import hps_pkg::*;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 over_temp;
    } duty_res_t;

    // Shadow copy of the register file and of the controller state.
    int set_point;
    int kp;
    int ki;
    int kd;
    int integ_bound;
    int duty_max;
    int cut_off;
    int integral;
    int last_err;

    int n_bad;
    int n_checked;
    int n_cut;

    duty_res_t duty_expected_q[$];
    duty_res_t want;

    // One controller step on a temperature sample; updates the shadow state.
    function automatic duty_res_t next_duty(int temp);
        duty_res_t res;
        int        err;
        int        derr;
        longint    sum;
        longint    ceiling;
        longint    duty;
        res = '0;
        if (temp > cut_off) begin
            integral      = 0;
            res.over_temp = 1'b1;
            return res;
        end
        err      = set_point - temp;
        integral = integral + err;
        if (integral > integ_bound)
            integral = integ_bound;
        else if (integral < -integ_bound)
            integral = -integ_bound;
        derr     = err - last_err;
        last_err = err;
        sum = 2 * longint'(kp) * err + longint'(ki) * integral + 4 * longint'(kd) * derr;
        ceiling = longint'(duty_max) <<< FRAC_SHIFT;
        if (sum < 0)
            duty = 0;
        else if (sum > ceiling)
            duty = duty_max;
        else
            duty = sum >>> FRAC_SHIFT;
        res.duty = duty[DUTY_BITS-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_point   = TARGET_TEMP_RST;
            kp          = PROP_GAIN_RST;
            ki          = INTEG_GAIN_RST;
            kd          = DERIV_GAIN_RST;
            integ_bound = INTEG_LIMIT_RST;
            duty_max    = MAX_DUTY_RST & ((1 << DUTY_BITS) - 1);
            cut_off     = OVER_TEMP_LIMIT_RST;
            integral    = 0;
            last_err    = 0;
            n_bad       = 0;
            n_checked   = 0;
            n_cut       = 0;
            duty_expected_q.delete();
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
            cutoffs    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET_TEMP:     set_point   = int'(signed'(cfg_data[TEMP_W-1:0]));
                    REG_PROP_GAIN:       kp          = int'(cfg_data[GAIN_W-1:0]);
                    REG_INTEG_GAIN:      ki          = int'(cfg_data[GAIN_W-1:0]);
                    REG_DERIV_GAIN:      kd          = int'(cfg_data[GAIN_W-1:0]);
                    REG_INTEG_LIMIT:     integ_bound = int'(cfg_data[LIMIT_W-1:0]);
                    REG_MAX_DUTY:        duty_max    = int'(cfg_data[DUTY_BITS-1:0]);
                    REG_OVER_TEMP_LIMIT: cut_off     = int'(signed'(cfg_data[TEMP_W-1:0]));
                    default: ;
                endcase
            end

            if (sample_ch.valid && sample_ch.ready)
                duty_expected_q.push_back(next_duty(int'(sample_ch.measured_temp)));

            if (result_ch.valid && result_ch.ready)
            begin
                n_checked++;
                if (duty_expected_q.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: unexpected result transfer: duty %0d over_temp %0b",
                             $time, result_ch.heater_duty, result_ch.over_temp);
                end
                else
                begin
                    want = duty_expected_q.pop_front();
                    if (want.over_temp)
                        n_cut++;
                    if (want.duty !== result_ch.heater_duty
                        || want.over_temp !== result_ch.over_temp)
                    begin
                        n_bad++;
                        $display("%0t: mismatch: expected duty %0d over_temp %0b, got duty %0d over_temp %0b",
                                 $time, want.duty, want.over_temp,
                                 result_ch.heater_duty, result_ch.over_temp);
                    end
                end
            end

            mismatches <= n_bad;
            pending    <= duty_expected_q.size();
            checked    <= n_checked;
            cutoffs    <= n_cut;
        end
    end

endmodule

/* tb/heater_pid_step_top_tb.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the heater PID step. The checker beside the block
// watches both channels and the configuration port; this module only drives.
module heater_pid_step_top_tb;
    import hps_pkg::*;

    localparam int DUTY_BITS       = 13;
    localparam int DUTY_MASK       = (1 << DUTY_BITS) - 1;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES    = 10;
    localparam int LIMIT_CYCLES    = 200000;

    // Index 7 has no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // How a register value is chosen.
    localparam int PICK_LOW       = 0;
    localparam int PICK_HIGH      = 1;
    localparam int PICK_PLAUSIBLE = 2;
    localparam int PICK_WILD      = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hps_in_if                           sample_ch();
    hps_out_if #(.DUTY_BITS(DUTY_BITS)) result_ch();

    int mismatches;
    int pending;
    int checked;
    int cutoffs;

    // When quiet is set, neither side idles.
    bit quiet = 1'b0;
    int cycle_count = 0;
    int samples_sent = 0;
    int settings = 1;
    int stall_left = 0;

    // Last values written to the setpoint and the cut-off, so that random
    // samples can be aimed at the interesting parts of the range.
    int cur_target = 7680;
    int cur_cutoff = 25600;

    reg_idx_t all_regs[7] = '{REG_TARGET_TEMP, REG_PROP_GAIN, REG_INTEG_GAIN,
                              REG_DERIV_GAIN, REG_INTEG_LIMIT, REG_MAX_DUTY,
                              REG_OVER_TEMP_LIMIT};

    // Opening samples under the reset settings: zero error, errors of one degree
    // either way, the cut-off boundary from both sides, the ends of the range,
    // alternating bit patterns, and a return from the cut-off with the last
    // error still held.
    int opening_temps[$] = '{0, 7680, 7936, 7424, 25600, 25601, 32767, -32768,
                             -1, 21845, -21846, 7680, 100, 26000, 7000};

    heater_pid_step_top #(
        .DUTY_BITS(DUTY_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hps_duty_checker #(
        .DUTY_BITS(DUTY_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .result_ch  (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .cutoffs    (cutoffs)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a healthy run takes a small fraction of this many cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run stopped by the cycle limit", $time);
            $display("heater_pid_step_top_tb failed");
            $finish;
        end
    end

    // The result side stalls in random bursts, except while quiet.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && stall_left == 0 && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    // Chooses a value for one register. Extreme values of registers narrower than the
    // port carry random bits above the register's width, which the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_value(reg_idx_t r, int kind);
        logic [7:0]            junk;
        logic [CFG_DATA_W-1:0] val;
        int                    v;
        junk = 8'($urandom());
        val  = CFG_DATA_W'($urandom());
        case (kind)
            PICK_LOW:
                case (r)
                    REG_TARGET_TEMP, REG_OVER_TEMP_LIMIT: val = {junk, 16'h8000};
                    REG_INTEG_LIMIT: val = '0;
                    REG_MAX_DUTY:    val = val & ~CFG_DATA_W'(DUTY_MASK);
                    default:         val = {junk, 16'h0000};
                endcase
            PICK_HIGH:
                case (r)
                    REG_TARGET_TEMP, REG_OVER_TEMP_LIMIT: val = {junk, 16'h7fff};
                    REG_INTEG_LIMIT: val = '1;
                    REG_MAX_DUTY:    val = val | CFG_DATA_W'(DUTY_MASK);
                    default:         val = {junk, 16'hffff};
                endcase
            PICK_PLAUSIBLE:
                case (r)
                    REG_TARGET_TEMP: val = CFG_DATA_W'($urandom_range(0, 25600));
                    REG_PROP_GAIN:   val = CFG_DATA_W'($urandom_range(0, 65535));
                    REG_INTEG_GAIN:  val = CFG_DATA_W'($urandom_range(0, 4096));
                    REG_DERIV_GAIN:  val = CFG_DATA_W'($urandom_range(0, 32768));
                    REG_INTEG_LIMIT: val = CFG_DATA_W'($urandom_range(0, 200000));
                    REG_MAX_DUTY:    val = CFG_DATA_W'($urandom_range(0, DUTY_MASK));
                    default:
                    begin
                        // Cut-off a little above the setpoint, as a real heater has it.
                        v = cur_target + int'($urandom_range(0, 5120));
                        if (v > 32767)
                            v = 32767;
                        val = CFG_DATA_W'(v);
                    end
                endcase
            default: ;
        endcase
        return val;
    endfunction

    // One register write on the configuration port, lasting one cycle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == REG_TARGET_TEMP)
            cur_target = int'(signed'(data[TEMP_W-1:0]));
        else if (idx == REG_OVER_TEMP_LIMIT)
            cur_cutoff = int'(signed'(data[TEMP_W-1:0]));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offers one sample, possibly after a short gap, and returns once the
    // transfer has taken place. Valid stays high for the next call unless that
    // call opens with a gap.
    task automatic send_temp(input logic [TEMP_W-1:0] t);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        @(negedge clk);
        if (gap != 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         = 1'b1;
        sample_ch.measured_temp = t;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Stops offering samples and waits until every result has been taken,
    // then drains the pipeline so that it is surely empty.
    task automatic settle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int       kind;
        int       drift;
        bit       wild;
        logic [TEMP_W-1:0] t;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.measured_temp = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Directed samples under the reset settings.
        foreach (opening_temps[i])
            send_temp(TEMP_W'(opening_temps[i]));
        settle();

        // Every register at its top value. A sample equal to the cut-off of
        // 32767 is not above it, so nothing here is cut off; the gains are at
        // their largest so the duty clamps hard at its ceiling.
        foreach (all_regs[k])
            write_reg(all_regs[k], pick_value(all_regs[k], PICK_HIGH));
        settings++;
        send_temp(16'sh7fff);
        send_temp(16'sh8000);
        send_temp(16'sh0000);
        send_temp(16'sh8000);
        settle();

        // Every register at its bottom value: zero gains, zero integral bound,
        // zero duty ceiling, and a cut-off at the very bottom of the range so
        // that only the lowest temperature escapes it.
        foreach (all_regs[k])
            write_reg(all_regs[k], pick_value(all_regs[k], PICK_LOW));
        write_reg(REG_NONE, '1);
        settings++;
        send_temp(16'sh8000);
        send_temp(16'sh8001);
        send_temp(16'sh0000);
        send_temp(16'sh7fff);

        // Random phases. Most use plausible settings with the odd extreme
        // register; about one in five uses raw random register data. Samples
        // mostly sit near the setpoint with a per-phase offset, so that the
        // integral walks steadily toward its bound, with some aimed at the
        // cut-off boundary, some at the ends of the range and some fully random.
        // One middle phase and the last phase run with no gaps and no stalls.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            quiet = (phase == 4) || (phase == NUM_PHASES - 1);
            wild  = ($urandom_range(0, 4) == 0);
            foreach (all_regs[k])
            begin
                if ($urandom_range(0, 7) == 0)
                    kind = $urandom_range(PICK_LOW, PICK_HIGH);
                else
                    kind = wild ? PICK_WILD : PICK_PLAUSIBLE;
                write_reg(all_regs[k], pick_value(all_regs[k], kind));
            end
            write_reg(REG_NONE, CFG_DATA_W'($urandom()));
            settings++;
            drift = int'($urandom_range(0, 3072)) - 1024;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        t = TEMP_W'(cur_target - drift + int'($urandom_range(0, 2048)) - 1024);
                    6:
                        t = TEMP_W'(cur_cutoff + int'($urandom_range(0, 8)) - 4);
                    7:
                        case ($urandom_range(0, 3))
                            0:       t = 16'h8000;
                            1:       t = 16'h7fff;
                            2:       t = 16'h0000;
                            default: t = 16'hffff;
                        endcase
                    default:
                        t = TEMP_W'($urandom());
                endcase
                send_temp(t);
            end
        end

        settle();

        $display("Sent %0d temperature samples under %0d register settings, with gaps and stalls on both channels.",
                 samples_sent, settings);
        $display("Checked %0d duty results, %0d of them under the over-temperature cut-off.",
                 checked, cutoffs);
        if (mismatches == 0)
            $display("heater_pid_step_top_tb passed");
        else
            $display("heater_pid_step_top_tb failed");
        $finish;
    end

endmodule
